/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on rising i_clk, skipped while i_rst_n is low.
`define ZBSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising i_clk, reset included.
`define ZBSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ZBSP_ASSERT(lbl, prop, msg)
`define ZBSP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/zbsp_pkg.sv */
`default_nettype none

package zbsp_pkg;

    localparam int GROUP_SIZE = 8;
    localparam int SLOT_W     = $clog2(GROUP_SIZE);
    localparam int KEPT_W     = SLOT_W + 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(GROUP_SIZE - 1);
    localparam logic [7:0]        MASK_LSB  = 8'h01;

    typedef enum logic [1:0] {
        S_ACCEPT = 2'b01,
        S_EMIT   = 2'b10
    } t_state;

    typedef struct packed {
        logic [7:0]        mask;
        logic [KEPT_W-1:0] kept;
        logic              slot_full;
    } t_grp_stat;

endpackage

`default_nettype wire

/* rtl/zbsp_group.sv */
`default_nettype none

module zbsp_group
    import zbsp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire logic [7:0]        i_data,
    input  wire logic              i_clear,
    input  wire logic [SLOT_W-1:0] i_rd_idx,
    output logic      [7:0]        o_rd_data,
    output t_grp_stat              o_stat
);

    logic [7:0]        r_bytes [GROUP_SIZE];
    logic [7:0]        r_mask;
    logic [SLOT_W-1:0] r_slot;
    logic [KEPT_W-1:0] r_kept;

    logic              nonzero;

    assign nonzero = (i_data != 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_slot <= '0;
            r_kept <= '0;
        end else if (i_clear) begin
            r_mask <= '0;
            r_slot <= '0;
            r_kept <= '0;
        end else if (i_wr) begin
            r_slot <= r_slot + 1'b1;
            if (nonzero) begin
                r_mask <= r_mask | (MASK_LSB << (LAST_SLOT - r_slot));
                r_kept <= r_kept + 1'b1;
            end
        end
    end

    // Kept bytes pack from entry zero in arrival order.
    always_ff @(posedge i_clk) begin
        if (i_wr && nonzero) begin
            r_bytes[r_kept[SLOT_W-1:0]] <= i_data;
        end
    end

    assign o_rd_data        = r_bytes[i_rd_idx];
    assign o_stat.mask      = r_mask;
    assign o_stat.kept      = r_kept;
    assign o_stat.slot_full = (r_slot == LAST_SLOT);

endmodule

`default_nettype wire

/* rtl/zero_byte_suppress_packer_top.sv */
// Takes one byte per accepted item; no output until a group closes (eighth byte or tlast).
// On the closing item, emission starts in the next cycle and sends the header, then the kept bytes,
// one output byte per cycle while the receiver does not stall, through a single read port.
// Input is held off during emission.
// i_rst_n is synchronous, active low: it empties the group and drops any pending output.
`default_nettype none

module zero_byte_suppress_packer_top
    import zbsp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic       i_s_tlast,   // message_end
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic      [7:0] o_m_tdata,   // [7:0] packed_byte
    output logic      [1:0] o_m_tuser,   // [0] is_header, [1] run_last
    output logic            o_m_tlast    // stream_last
);

    t_state            r_state, n_state;
    logic [KEPT_W-1:0] r_idx, n_idx;
    logic              r_last, n_last;
    logic              r_m_valid;
    logic [7:0]        r_m_data;
    logic [1:0]        r_m_user;
    logic              r_m_last;

    t_grp_stat         stat;
    logic [7:0]        rd_data;
    logic [SLOT_W-1:0] rd_idx;
    logic              s_accept;
    logic              closing;
    logic              load;
    logic              run_end;
    logic              grp_clear;

    assign o_s_tready = (r_state == S_ACCEPT);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign closing    = stat.slot_full || i_s_tlast;
    assign load       = (r_state == S_EMIT) && (!r_m_valid || i_m_tready);
    assign run_end    = (r_idx == stat.kept);
    assign grp_clear  = load && run_end;

    // Index zero is the header; index k reads kept byte k-1.
    assign rd_idx = SLOT_W'(r_idx - 1'b1);

    zbsp_group u_group (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (s_accept),
        .i_data   (i_s_tdata),
        .i_clear  (grp_clear),
        .i_rd_idx (rd_idx),
        .o_rd_data(rd_data),
        .o_stat   (stat)
    );

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_last  = r_last;
        unique case (r_state)
            S_ACCEPT: begin
                if (s_accept && closing) begin
                    n_state = S_EMIT;
                    n_idx   = '0;
                    n_last  = i_s_tlast;
                end
            end
            S_EMIT: begin
                if (load) begin
                    if (run_end) begin
                        n_state = S_ACCEPT;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACCEPT;
            r_idx     <= '0;
            r_last    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_last  <= n_last;
            if (load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_data <= (r_idx == '0) ? stat.mask : rd_data;
            r_m_user <= {run_end, (r_idx == '0)};
            r_m_last <= r_last && run_end;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

`include "assert_macros.svh"

    `ZBSP_ASSERT(a_idx_range, (r_state == S_EMIT) |-> (r_idx <= stat.kept), "emit index past kept count")
    `ZBSP_ASSERT(a_close_starts, (s_accept && closing) |=> (r_state == S_EMIT && r_idx == '0), "closing item did not start emission at header")
    `ZBSP_ASSERT(a_idx_hold, (r_state == S_EMIT && !load) |=> $stable(r_idx), "emit index moved without a load")
    `ZBSP_ASSERT(a_group_cleared, grp_clear |=> (stat.kept == '0 && stat.mask == 8'd0), "group not emptied after emission")

endmodule

`default_nettype wire

/* tb/zbsp_checker.sv */
`default_nettype none

module zbsp_checker
    import zbsp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic       i_s_tlast,   // message_end
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [7:0] packed_byte
    input  wire logic [1:0] i_m_tuser,   // [0] is_header, [1] run_last
    input  wire logic       i_m_tlast,   // stream_last
    output int              o_fail_count,
    output int              o_pending,
    output int              o_items,
    output int              o_results,
    output int              o_headers
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] val;
        logic       hdr;
        logic       grp_end;
        logic       msg_end;
    } t_packed_out;

    // open group as the packer should hold it
    logic [7:0]        grp_kept_bytes [GROUP_SIZE];
    logic [7:0]        grp_mask;
    logic [SLOT_W-1:0] grp_slot;
    logic [KEPT_W-1:0] grp_kept;

    t_packed_out packed_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_items      = 0;
        o_results    = 0;
        o_headers    = 0;
        grp_mask     = '0;
        grp_slot     = '0;
        grp_kept     = '0;
    end

    // Fold one message byte into the open group; on close, queue header then kept bytes.
    function automatic void fold_byte(input logic [7:0] d, input logic fin);
        t_packed_out r;
        logic        full;
        int          k;
        if (d != 8'h00) begin
            grp_mask = grp_mask | (MASK_LSB << (LAST_SLOT - grp_slot));
            grp_kept_bytes[grp_kept[SLOT_W-1:0]] = d;
            grp_kept = grp_kept + 1'b1;
        end
        full     = (grp_slot == LAST_SLOT);
        grp_slot = grp_slot + 1'b1;
        if (full || fin) begin
            r.val     = grp_mask;
            r.hdr     = 1'b1;
            r.grp_end = (grp_kept == 0);
            r.msg_end = fin && (grp_kept == 0);
            packed_due = {packed_due, r};
            for (k = 0; k < int'(grp_kept); k++) begin
                r.val     = grp_kept_bytes[k];
                r.hdr     = 1'b0;
                r.grp_end = (k + 1 == int'(grp_kept));
                r.msg_end = fin && r.grp_end;
                packed_due = {packed_due, r};
            end
            grp_mask = '0;
            grp_slot = '0;
            grp_kept = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_packed_out seen;
        t_packed_out want;
        if (!i_rst_n) begin
            packed_due.delete();
            grp_mask = '0;
            grp_slot = '0;
            grp_kept = '0;
        end else begin
            // results leave before this edge's item can produce any
            if (i_m_tvalid && i_m_tready) begin
                seen = '{val: i_m_tdata, hdr: i_m_tuser[0], grp_end: i_m_tuser[1],
                         msg_end: i_m_tlast};
                o_results++;
                if (seen.hdr) o_headers++;
                if (packed_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("[%0t] unexpected output %02h hdr=%0b run_last=%0b last=%0b",
                                 $realtime, seen.val, seen.hdr, seen.grp_end, seen.msg_end);
                end else begin
                    want = packed_due.pop_front();
                    if (seen.val !== want.val || seen.hdr !== want.hdr ||
                        seen.grp_end !== want.grp_end || seen.msg_end !== want.msg_end) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX)
                            $display({"[%0t] output %0d: expected %02h hdr=%0b run_last=%0b ",
                                      "last=%0b, got %02h hdr=%0b run_last=%0b last=%0b"},
                                     $realtime, o_results, want.val, want.hdr, want.grp_end,
                                     want.msg_end, seen.val, seen.hdr, seen.grp_end,
                                     seen.msg_end);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                o_items++;
                fold_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = packed_due.size();
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 480;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_TAIL  = 20;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_BURSTY,
        RX_TOGGLE
    } t_rx_mode;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int headers_seen;

    int items_sent  = 0;
    int messages    = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    zero_byte_suppress_packer_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    zbsp_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_items      (items_seen),
        .o_results    (results_seen),
        .o_headers    (headers_seen)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d outputs still due", cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver backpressure: switch among a few stall styles every so often.
    always @(negedge clk) begin
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_OPEN: begin
                m_tready <= 1'b1;
            end
            RX_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            RX_BURSTY: begin
                if (hold_left > 0) begin
                    hold_left--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    hold_left = $urandom_range(1, 12);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
            default: begin
                m_tready <= ~m_tready;
            end
        endcase
    end

    // Present one byte at the falling edge and hold it until the packer takes it.
    task automatic send_byte(input logic [7:0] d, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tlast  = fin;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_message(input logic [7:0] bytes_in [$]);
        int k;
        for (k = 0; k < bytes_in.size(); k++)
            send_byte(bytes_in[k], k == bytes_in.size() - 1);
        messages++;
    endtask

    // Hold the input off until every queued output has drained.
    task automatic wait_drained();
        s_tvalid   = 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic send_random_message();
        logic [7:0] msg [$];
        int         len;
        int         zero_pct;
        int         k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: len = $urandom_range(1, 7);
            4, 5, 6:    len = $urandom_range(8, 17);
            7, 8:       len = 8 * $urandom_range(1, 2);
            default:    len = $urandom_range(18, 40);
        endcase
        case ($urandom_range(0, 4))
            0:       zero_pct = 0;
            1:       zero_pct = 25;
            2:       zero_pct = 50;
            3:       zero_pct = 90;
            default: zero_pct = 100;
        endcase
        for (k = 0; k < len; k++)
            msg = {msg, (($urandom_range(0, 99) < zero_pct) ? 8'h00
                                                             : 8'($urandom_range(1, 255)))};
        send_message(msg);
    endtask

    initial begin
        logic [7:0] msg [$];
        bit         paused_mid;
        paused_mid = 1'b0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // full group closing the message, mixed zero and nonzero bytes
        msg = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h00, 8'h7F};
        send_message(msg);
        // one-byte messages: lone zero gives a bare header, lone nonzero a pair
        msg = '{8'h00};
        send_message(msg);
        msg = '{8'hC3};
        send_message(msg);
        // full all-zero group mid-message, then a short closing group
        msg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h12, 8'h00, 8'h34};
        send_message(msg);
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            send_random_message();
            if (!paused_mid && items_sent >= ITEM_TARGET / 2) begin
                wait_drained();
                paused_mid = 1'b1;
            end
        end
        wait_drained();
        repeat (DRAIN_TAIL) @(negedge clk);

        $display("Sent %0d bytes in %0d messages; checked %0d packed bytes, %0d of them headers.",
                 items_seen, messages, results_seen, headers_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d outputs never arrived", fail_count, pending);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/zbsp_pkg.sv
rtl/zbsp_group.sv
rtl/zero_byte_suppress_packer_top.sv
tb/zbsp_checker.sv
tb/tb_top.sv
